// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the edge magnitude block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define ED3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ED3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/ed3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed3_pkg
// Types, widths and kernel coefficients of the 3x3 edge magnitude block.
// ----------------------------------------------------------------------------
package ed3_pkg;

  localparam int NPIX        = 9;
  localparam int PIX_W       = 8;
  localparam int COEF_W      = 4;
  localparam int SUM_W       = 12;
  localparam int ABS_W       = 10;
  localparam int SQ_W        = 2 * ABS_W;
  localparam int SSUM_W      = SQ_W + 1;
  localparam int RAD_W       = 16;
  localparam int ROOT_W      = 8;
  localparam int SQRT_STAGES = ROOT_W / 2;
  localparam int LAT         = 4 + SQRT_STAGES;
  localparam int CLIP_MAX    = 255;
  localparam int CLIP_SQ     = CLIP_MAX * CLIP_MAX;

  typedef enum logic [1:0] {
    MODE_SOBEL   = 2'd0,
    MODE_PREWITT = 2'd1,
    MODE_LAPLACE = 2'd2,
    MODE_BAD     = 2'd3
  } mode_t;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef pix_t                     win_t [NPIX];
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t                    coef_vec_t [NPIX];

  localparam coef_vec_t K_SOBEL_X   = '{4'sd1, 4'sd0, -4'sd1, 4'sd2, 4'sd0, -4'sd2,
                                        4'sd1, 4'sd0, -4'sd1};
  localparam coef_vec_t K_SOBEL_Y   = '{-4'sd1, -4'sd2, -4'sd1, 4'sd0, 4'sd0, 4'sd0,
                                        4'sd1, 4'sd2, 4'sd1};
  localparam coef_vec_t K_PREWITT_X = '{4'sd1, 4'sd0, -4'sd1, 4'sd1, 4'sd0, -4'sd1,
                                        4'sd1, 4'sd0, -4'sd1};
  localparam coef_vec_t K_PREWITT_Y = '{-4'sd1, -4'sd1, -4'sd1, 4'sd0, 4'sd0, 4'sd0,
                                        4'sd1, 4'sd1, 4'sd1};
  localparam coef_vec_t K_LAPLACE   = '{4'sd1, 4'sd1, 4'sd1, 4'sd1, -4'sd8, 4'sd1,
                                        4'sd1, 4'sd1, 4'sd1};

endpackage

// File: hw/rtl/ed3_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed3_lane
// One kernel lane: weighted sum of the nine window pixels, registered.
// ----------------------------------------------------------------------------
module ed3_lane
  import ed3_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  win_t                    win,
  input  coef_vec_t               coef,
  output logic signed [SUM_W-1:0] sum
);

  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] sum_r;

  always_comb begin
    logic signed [SUM_W-1:0] c_ext;
    logic signed [SUM_W-1:0] p_ext;
    sum_nxt = '0;
    for (int i = 0; i < NPIX; i++) begin
      c_ext   = SUM_W'(coef[i]);
      p_ext   = SUM_W'({1'b0, win[i]});
      sum_nxt = SUM_W'(sum_nxt + c_ext * p_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// File: hw/rtl/ed3_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed3_isqrt
// Pipelined integer square root, two result bits resolved per stage.
// ----------------------------------------------------------------------------
module ed3_isqrt
  import ed3_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  r2;
  } isq_step_t;

  function automatic isq_step_t isq_step(isq_step_t cur, logic [RAD_W-1:0] s, int k);
    isq_step_t        res;
    logic [RAD_W-1:0] cand;
    res  = cur;
    cand = RAD_W'(cur.r2 + (RAD_W'(cur.root) << (k + 1)) + (RAD_W'(1) << (2 * k)));
    if (cand <= s) begin
      res.root = cur.root | (ROOT_W'(1) << k);
      res.r2   = cand;
    end
    return res;
  endfunction

  isq_step_t        step_r [SQRT_STAGES];
  logic [RAD_W-1:0] rad_r  [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    isq_step_t        cur;
    isq_step_t        mid;
    isq_step_t        step_nxt;
    logic [RAD_W-1:0] s_in;

    if (g == 0) begin : g_first
      assign cur  = '0;
      assign s_in = rad;
    end else begin : g_next
      assign cur  = step_r[g-1];
      assign s_in = rad_r[g-1];
    end

    always_comb begin
      mid      = isq_step(cur, s_in, ROOT_W - 1 - 2 * g);
      step_nxt = isq_step(mid, s_in, ROOT_W - 2 - 2 * g);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        step_r[g] <= step_nxt;
        rad_r[g]  <= s_in;
      end
    end
  end

  assign root = step_r[SQRT_STAGES-1].root;

endmodule

// File: hw/rtl/ed3_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed3_merge
// Combines the lane sums: gradient magnitude or clipped Laplace response.
// ----------------------------------------------------------------------------
module ed3_merge
  import ed3_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [SUM_W-1:0] gx,
  input  logic signed [SUM_W-1:0] gy,
  input  logic signed [SUM_W-1:0] lap,
  input  mode_t                   mode,
  output logic [PIX_W-1:0]        edge_value,
  output logic                    bad_mode
);

  typedef struct packed {
    mode_t            mode;
    logic [PIX_W-1:0] lap;
    logic             big;
  } ed3_side_t;

  logic [ABS_W-1:0]  ax;
  logic [ABS_W-1:0]  ay;
  logic [PIX_W-1:0]  lap_clip;
  logic [SQ_W-1:0]   sqx_r;
  logic [SQ_W-1:0]   sqy_r;
  ed3_side_t         side2_r;
  logic [SSUM_W-1:0] ssum;
  logic [RAD_W-1:0]  rad_r;
  ed3_side_t         side3_nxt;
  ed3_side_t         side3_r;
  ed3_side_t         side_r [SQRT_STAGES];
  logic [ROOT_W-1:0] root;
  ed3_side_t         side_last;
  logic [PIX_W-1:0]  edge_nxt;
  logic              bad_nxt;
  logic [PIX_W-1:0]  edge_r;
  logic              bad_r;

  assign ax = ABS_W'(gx[SUM_W-1] ? -gx : gx);
  assign ay = ABS_W'(gy[SUM_W-1] ? -gy : gy);

  always_comb begin
    if (lap[SUM_W-1]) begin
      lap_clip = '0;
    end else if (lap[SUM_W-2:PIX_W] != '0) begin
      lap_clip = PIX_W'(CLIP_MAX);
    end else begin
      lap_clip = lap[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r        <= ax * ax;
      sqy_r        <= ay * ay;
      side2_r.mode <= mode;
      side2_r.lap  <= lap_clip;
      side2_r.big  <= 1'b0;
    end
  end

  assign ssum = SSUM_W'(sqx_r) + SSUM_W'(sqy_r);

  always_comb begin
    side3_nxt     = side2_r;
    side3_nxt.big = (ssum >= SSUM_W'(CLIP_SQ));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r   <= ssum[RAD_W-1:0];
      side3_r <= side3_nxt;
    end
  end

  ed3_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side3_r;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign side_last = side_r[SQRT_STAGES-1];

  always_comb begin
    edge_nxt = '0;
    bad_nxt  = 1'b0;
    unique case (side_last.mode)
      MODE_SOBEL, MODE_PREWITT: begin
        edge_nxt = side_last.big ? PIX_W'(CLIP_MAX) : root;
      end
      MODE_LAPLACE: begin
        edge_nxt = side_last.lap;
      end
      MODE_BAD: begin
        bad_nxt = 1'b1;
      end
      default: begin
        bad_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      edge_r <= edge_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign edge_value = edge_r;
  assign bad_mode   = bad_r;

endmodule

// File: hw/rtl/edge_magnitude_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_magnitude_3x3
// 3x3 edge detector giving Sobel, Prewitt or Laplace edge strength.
// ----------------------------------------------------------------------------
// Each input transfer carries one 3x3 window of 8-bit pixels on in_tdata.
// Each output transfer carries the edge strength of that window on
// out_tdata and the unsupported-mode flag on out_tuser.
// The mode register is written through cfg_we and cfg_wdata and resets to
// Sobel; the user must write it only while no window is in flight, since
// the block itself does not enforce this.
// Three kernel lanes form the horizontal, vertical and Laplace sums in
// parallel, and a merge stage squares, adds, takes a four-stage
// pipelined square root (two bits per stage) and selects the result.
// Throughput is one window per clock while out_tready stays high.
// When the receiver holds out_tready low with a result waiting, the
// whole pipeline freezes and in_tready falls in the same cycle.
// Reset empties the pipeline; no result is pending afterward.
// ----------------------------------------------------------------------------
module edge_magnitude_3x3
  import ed3_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // pix_top_left, pix_top_mid, pix_top_right, pix_mid_left, pix_center,
  // pix_mid_right, pix_bot_left, pix_bot_mid, pix_bot_right
  input  logic [NPIX*PIX_W-1:0]   in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // edge_value
  output logic [PIX_W-1:0]        out_tdata,
  // bad_mode
  output logic                    out_tuser,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_wdata
);

  mode_t                   mode_r;
  mode_t                   mode_s1_r;
  logic [LAT-1:0]          v_r;
  logic                    en;
  win_t                    win;
  coef_vec_t               coef_x;
  coef_vec_t               coef_y;
  logic signed [SUM_W-1:0] gx;
  logic signed [SUM_W-1:0] gy;
  logic signed [SUM_W-1:0] lap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SOBEL;
    end else if (cfg_we) begin
      mode_r <= mode_t'(cfg_wdata);
    end
  end

  assign en        = !v_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  for (genvar i = 0; i < NPIX; i++) begin : g_unpack
    assign win[i] = in_tdata[i*PIX_W +: PIX_W];
  end

  assign coef_x = (mode_r == MODE_SOBEL) ? K_SOBEL_X : K_PREWITT_X;
  assign coef_y = (mode_r == MODE_SOBEL) ? K_SOBEL_Y : K_PREWITT_Y;

  ed3_lane u_lane_x (
    .clk  (clk),
    .en   (en),
    .win  (win),
    .coef (coef_x),
    .sum  (gx)
  );

  ed3_lane u_lane_y (
    .clk  (clk),
    .en   (en),
    .win  (win),
    .coef (coef_y),
    .sum  (gy)
  );

  ed3_lane u_lane_lap (
    .clk  (clk),
    .en   (en),
    .win  (win),
    .coef (K_LAPLACE),
    .sum  (lap)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      mode_s1_r <= mode_r;
    end
  end

  ed3_merge u_merge (
    .clk        (clk),
    .en         (en),
    .gx         (gx),
    .gy         (gy),
    .lap        (lap),
    .mode       (mode_s1_r),
    .edge_value (out_tdata),
    .bad_mode   (out_tuser)
  );

  assign out_tvalid = v_r[LAT-1];

`include "assert_macros.svh"

  `ED3_ASSERT(a_bad_gives_zero, out_tvalid && out_tuser |-> out_tdata == '0, "edge in bad mode")
  `ED3_ASSERT(a_pipe_advance, v_r[LAT-2] && en |=> out_tvalid, "advanced item did not reach output")
  `ED3_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid right after reset")

endmodule

// File: dv/tb_edge_magnitude_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_magnitude_3x3
// Self-checking stream bench for the 3x3 edge magnitude block.
// ----------------------------------------------------------------------------
// Windows are sent under every mode. A short directed set covers flat,
// saturating, negative-Laplace and unsupported-mode windows. Random windows
// follow: uniform noise, near-flat patches, step edges and black/white mixes.
// A scoreboard predicts each edge strength with exact integer math and
// checks the results in order. Both sides of the stream stall at random,
// except during one phase that runs at full rate.
// ----------------------------------------------------------------------------
module tb_edge_magnitude_3x3;
  import ed3_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] edge_value;
    logic             bad_mode;
  } edge_result_t;

  class edge_scoreboard;
    edge_result_t pending_q[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function edge_result_t predict(win_t w, mode_t m);
      edge_result_t res;
      int p[NPIX];
      int wt, gx, gy, lap, sq, root, trial;
      res.edge_value = '0;
      res.bad_mode   = 1'b0;
      for (int i = 0; i < NPIX; i++) p[i] = int'(w[i]);
      case (m)
        MODE_SOBEL, MODE_PREWITT: begin
          wt   = (m == MODE_SOBEL) ? 2 : 1;
          gx   = p[0] + wt * p[3] + p[6] - p[2] - wt * p[5] - p[8];
          gy   = p[6] + wt * p[7] + p[8] - p[0] - wt * p[1] - p[2];
          sq   = gx * gx + gy * gy;
          root = 0;
          if (sq >= CLIP_SQ) begin
            root = CLIP_MAX;
          end else begin
            for (int b = 7; b >= 0; b--) begin
              trial = root | (1 << b);
              if (trial * trial <= sq) root = trial;
            end
          end
          res.edge_value = root[PIX_W-1:0];
        end
        MODE_LAPLACE: begin
          lap = p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8] - 8 * p[4];
          if (lap < 0) lap = 0;
          if (lap > CLIP_MAX) lap = CLIP_MAX;
          res.edge_value = lap[PIX_W-1:0];
        end
        default: begin
          res.bad_mode = 1'b1;
        end
      endcase
      return res;
    endfunction

    function void note_window(win_t w, mode_t m);
      pending_q.insert(pending_q.size(), predict(w, m));
    endfunction

    task check_result(logic [PIX_W-1:0] value, logic flag);
      edge_result_t exp_r;
      if (pending_q.size() == 0) begin
        report($sformatf("result %0d flag %0b with no window outstanding", value, flag));
      end else begin
        exp_r = pending_q.pop_front();
        if (value !== exp_r.edge_value) begin
          report($sformatf("edge_value %0d, expected %0d", value, exp_r.edge_value));
        end
        if (flag !== exp_r.bad_mode) begin
          report($sformatf("bad_mode %0b, expected %0b", flag, exp_r.bad_mode));
        end
      end
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [NPIX*PIX_W-1:0] in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [1:0]            cfg_wdata  = '0;

  mode_t          cur_mode = MODE_SOBEL;
  bit             steady   = 1'b0;
  edge_scoreboard sb;

  always #2 clk = ~clk;

  edge_magnitude_3x3 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk) begin
    win_t seen;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        for (int i = 0; i < NPIX; i++) seen[i] = in_tdata[i*PIX_W +: PIX_W];
        sb.note_window(seen, cur_mode);
      end
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  task automatic send_window(win_t w);
    logic [NPIX*PIX_W-1:0] word;
    for (int i = 0; i < NPIX; i++) word[i*PIX_W +: PIX_W] = w[i];
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode  = m;
  endtask

  function automatic win_t directed_window(int k);
    win_t w;
    case (k)
      0: w = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      1: w = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
      2: w = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0};
      3: w = '{8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255};
      4: w = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
      default: w = '{8'd40, 8'd50, 8'd60, 8'd40, 8'd45, 8'd60, 8'd40, 8'd50, 8'd60};
    endcase
    return w;
  endfunction

  function automatic win_t random_window();
    win_t w;
    int kind, base, amp, hi, lo, dir, v, row, col;
    bit on_hi;
    kind = $urandom_range(0, 9);
    base = $urandom_range(0, 255);
    amp  = $urandom_range(1, 24);
    hi   = $urandom_range(0, 255);
    lo   = $urandom_range(0, 255);
    dir  = $urandom_range(0, 3);
    for (int i = 0; i < NPIX; i++) begin
      row = i / 3;
      col = i % 3;
      if (kind < 4) begin
        w[i] = 8'($urandom_range(0, 255));
      end else if (kind < 7) begin
        v    = base - amp + int'($urandom_range(0, 2 * amp));
        w[i] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
      end else if (kind < 9) begin
        on_hi = (dir == 0) ? (col == 0) :
                (dir == 1) ? (row == 0) :
                (dir == 2) ? (row + col < 2) : (col == 1);
        w[i]  = on_hi ? hi[7:0] : lo[7:0];
      end else begin
        w[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
    end
    return w;
  endfunction

  initial begin
    mode_t all_modes[4];
    mode_t phase_mode;
    all_modes = '{MODE_SOBEL, MODE_PREWITT, MODE_LAPLACE, MODE_BAD};
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int m = 0; m < 4; m++) begin
      write_mode(all_modes[m]);
      for (int k = 0; k < 6; k++) send_window(directed_window(k));
      drain();
    end

    for (int ph = 0; ph < 9; ph++) begin
      phase_mode = (ph == 0) ? MODE_BAD : (ph == 1) ? MODE_SOBEL :
                   (ph == 2) ? MODE_LAPLACE : (ph == 3) ? MODE_PREWITT :
                   all_modes[$urandom_range(0, 3)];
      write_mode(phase_mode);
      steady = (ph == 4);
      for (int n = 0; n < 50; n++) send_window(random_window());
      drain();
      steady = 1'b0;
    end

    repeat (LAT + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb_edge_magnitude_3x3: done, clean");
    end else begin
      $display("tb_edge_magnitude_3x3: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_edge_magnitude_3x3: done, errors");
    $finish;
  end

endmodule
